// ----- sv/pgl_pkg.sv -----
// shared types and constants for the polyline group length block
`timescale 1ns / 1ps
`default_nettype none

package pgl_pkg;

  localparam int COORD_BITS = 24;

  // widths derived from the coordinate width
  localparam int DIFF_W = COORD_BITS + 2;     // signed difference of two coords
  localparam int ABS_W  = COORD_BITS + 1;     // magnitude of that difference
  localparam int SQ_W   = 2 * ABS_W;          // square of one axis
  localparam int SUM_W  = SQ_W + 2;           // sum of three squares
  localparam int ROOT_W = SUM_W / 2;          // floor square root
  localparam int STEP_W = $clog2(ROOT_W);     // root step counter

  localparam int LEN_W     = 40;
  localparam int GROUP_W   = 8;
  localparam int SEEN_W    = 2;
  localparam int KIND_W    = 2;
  localparam int MIN_POINTS = 3;

  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_GROUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic diff_en;
    logic sq_en;
  } lane_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  value;
    logic              last;
  } out_word_t;

endpackage

`default_nettype wire

// ----- sv/polyline_group_length.sv -----
// top level: point intake, axis lanes, merge, square root, group and total sums
`timescale 1ns / 1ps
`default_nettype none

// polyline_group_length takes 3-D path points (signed micrometres) one word at a
// time. Every point after the first of a list adds a segment whose length is the
// floor square root of dx*dx + dy*dy + dz*dz. Three axis lanes form the squared
// differences side by side, a merge stage adds them, and a shared bit-serial root
// unit delivers one root bit per cycle. Segments are summed into groups of
// parts_per_group; each finished group is emitted (kind 0) and added to the list
// total, which is emitted (kind 1) on the point flagged end_of_list. A trailing
// partial group is dropped, a list shorter than three points gives one error
// word (kind 2, length 0) instead, and both sums saturate at 2^40-1.
// parts_per_group of zero never completes a group. The root unit runs
// COORD_BITS + 2 steps for each point, and the next point is taken once the
// previous one is queued. A two-word output queue holds results so that a
// stalled consumer does not stop intake until it fills.
// cfg_wr_data may only be written while the block is idle.
module polyline_group_length
  import pgl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [GROUP_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic signed [COORD_BITS-1:0] in_z_coord,
  input  logic                 in_end_of_list,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_result_kind,
  output logic [LEN_W-1:0]     out_length_value,
  output logic                 out_last_of_run
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [GROUP_W-1:0]  ppg_r;

  // current point and list state
  coord_t              pt_r [3];
  coord_t              prev_r [3];
  logic                last_r;
  logic                have_prev_r;
  logic [SEEN_W-1:0]   seen_r;
  logic [GROUP_W-1:0]  seg_cnt_r;
  logic [LEN_W-1:0]    group_r;
  logic [LEN_W-1:0]    total_r;
  logic                seg_added_r;

  // lanes and merge
  lane_ctl_t           lane_ctl;
  coord_t              lane_cur [3];
  logic [SQ_W-1:0]     lane_sq [3];
  logic [SUM_W-1:0]    sum_r;

  // root unit
  logic                sq_start;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;

  // output queue, head in slot 0
  out_word_t           q_r [2];
  out_word_t           q_nxt [2];
  logic [1:0]          q_cnt_r, q_cnt_nxt;
  logic [1:0]          q_base;

  logic                in_fire;
  logic                pop;
  logic                push;
  logic [SEEN_W-1:0]   seen_inc;
  logic                err;
  logic                grp_done;
  logic [LEN_W-1:0]    total_new;
  out_word_t           w0, w1;
  logic [1:0]          n_words;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign lane_cur[0] = in_x_coord;
  assign lane_cur[1] = in_y_coord;
  assign lane_cur[2] = in_z_coord;

  assign lane_ctl.diff_en = in_fire;
  assign lane_ctl.sq_en   = (state_r == S_DIFF);

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      pgl_lane u_lane (
        .clk  (clk),
        .ctl  (lane_ctl),
        .cur  (lane_cur[g]),
        .prev (prev_r[g]),
        .sq   (lane_sq[g])
      );
    end
  endgenerate

  assign sq_start = (state_r == S_SUM);

  pgl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // list bookkeeping for the point in flight
  always_comb begin
    seen_inc  = (seen_r < SEEN_W'(MIN_POINTS)) ? seen_r + 1'b1 : seen_r;
    err       = last_r && (seen_inc < SEEN_W'(MIN_POINTS));
    grp_done  = seg_added_r && (ppg_r != '0) && (seg_cnt_r >= ppg_r);
    total_new = grp_done ? sat_add(total_r, group_r) : total_r;
  end

  // result words for this point
  always_comb begin
    w0      = '0;
    w1      = '0;
    n_words = 2'd0;
    if (err) begin
      w0      = '{kind: KIND_ERROR, value: '0, last: 1'b1};
      n_words = 2'd1;
    end else if (grp_done) begin
      w0      = '{kind: KIND_GROUP, value: group_r, last: !last_r};
      w1      = '{kind: KIND_TOTAL, value: total_new, last: 1'b1};
      n_words = last_r ? 2'd2 : 2'd1;
    end else if (last_r) begin
      w0      = '{kind: KIND_TOTAL, value: total_new, last: 1'b1};
      n_words = 2'd1;
    end
  end

  assign push = (state_r == S_WRITE) && (n_words <= (2'd2 - q_cnt_r));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) begin
        state_nxt = S_DIFF;
      end
      S_DIFF:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_ROOT;
      S_ROOT:  if (sq_done) begin
        state_nxt = S_ACC;
      end
      S_ACC:   state_nxt = S_WRITE;
      S_WRITE: if (push) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output queue update
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    q_base   = q_cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_base   = q_cnt_r - 1'b1;
    end
    if (push) begin
      unique case (q_base)
        2'd0: begin
          q_nxt[0] = w0;
          q_nxt[1] = w1;
        end
        2'd1: q_nxt[1] = w0;
        default: ;
      endcase
    end
    q_cnt_nxt = q_base + (push ? n_words : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ppg_r       <= GROUP_W'(1);
      q_cnt_r     <= 2'd0;
      have_prev_r <= 1'b0;
      seen_r      <= '0;
      seg_cnt_r   <= '0;
      group_r     <= '0;
      total_r     <= '0;
      seg_added_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (cfg_wr_en) begin
        ppg_r <= cfg_wr_data;
      end

      // add the segment into the open group
      if (state_r == S_ACC) begin
        seg_added_r <= !err && have_prev_r;
        if (!err && have_prev_r) begin
          group_r   <= sat_add(group_r, LEN_W'(sq_root));
          seg_cnt_r <= (seg_cnt_r == GROUP_MAX) ? seg_cnt_r : seg_cnt_r + 1'b1;
        end
      end

      // commit the point once its words fit in the queue
      if (push) begin
        if (err || last_r) begin
          have_prev_r <= 1'b0;
          seen_r      <= '0;
          seg_cnt_r   <= '0;
          group_r     <= '0;
          total_r     <= '0;
          for (int i = 0; i < 3; i++) begin
            prev_r[i] <= '0;
          end
        end else begin
          have_prev_r <= 1'b1;
          seen_r      <= seen_inc;
          for (int i = 0; i < 3; i++) begin
            prev_r[i] <= pt_r[i];
          end
          if (grp_done) begin
            total_r   <= total_new;
            group_r   <= '0;
            seg_cnt_r <= '0;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_r[0] <= in_x_coord;
      pt_r[1] <= in_y_coord;
      pt_r[2] <= in_z_coord;
      last_r  <= in_end_of_list;
    end
    if (state_r == S_MUL) begin
      sum_r <= SUM_W'(lane_sq[0]) + SUM_W'(lane_sq[1]) + SUM_W'(lane_sq[2]);
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_valid        = (q_cnt_r != 2'd0);
  assign out_result_kind  = q_r[0].kind;
  assign out_length_value = q_r[0].value;
  assign out_last_of_run  = q_r[0].last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_root_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_ROOT)
    else $error("root finished outside its wait state");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_ERROR) |->
      (out_last_of_run && out_length_value == '0))
    else $error("error word must be last and zero length");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DIFF)
    else $error("accepted point did not start the lanes");
`endif

endmodule

`default_nettype wire

// ----- sv/pgl_lane.sv -----
// one axis lane: registered absolute difference, then registered square
`timescale 1ns / 1ps
`default_nettype none

module pgl_lane
  import pgl_pkg::*;
(
  input  logic                clk,
  input  lane_ctl_t           ctl,
  input  coord_t              cur,
  input  coord_t              prev,
  output logic [SQ_W-1:0]     sq
);

  logic signed [DIFF_W-1:0] diff;
  logic [ABS_W-1:0]         mag_nxt;
  logic [ABS_W-1:0]         mag_r;
  logic [SQ_W-1:0]          sq_r;

  always_comb begin
    diff = DIFF_W'(cur) - DIFF_W'(prev);
    if (diff[DIFF_W-1]) begin
      mag_nxt = ABS_W'(-diff);
    end else begin
      mag_nxt = ABS_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      mag_r <= mag_nxt;
    end
    if (ctl.sq_en) begin
      sq_r <= mag_r * mag_r;
    end
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

// ----- sv/pgl_sqrt.sv -----
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pgl_sqrt
  import pgl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    radicand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  logic [SUM_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;

  always_comb begin
    rem_sh   = {rem_r[ROOT_W-1:0], rad_r[SUM_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = STEP_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire
